@@ src/hbu_pkg.sv @@
package hbu_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int HIST_DEPTH = 5;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int ACC_W      = 26;
    localparam int FRAC_W     = 8;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam int CFG_IDX_W  = 2;

    // Coefficients 38400, -6400, 768 share a factor of 256; the factor folds
    // into the final scaling so that (acc + 32768) / 65536 becomes
    // (t + 128) / 256 with t built from the reduced coefficients.
    localparam logic signed [ACC_W-1:0] COEF_INNER = ACC_W'(150);
    localparam logic signed [ACC_W-1:0] COEF_MID   = ACC_W'(25);
    localparam logic signed [ACC_W-1:0] COEF_OUTER = ACC_W'(3);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(128);

    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);

    localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE_REQUEST  = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

@@ src/hbu_tap_cell.sv @@
module hbu_tap_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_advance,
    input  hbu_pkg::t_sample i_tap_in,
    output hbu_pkg::t_sample o_tap
);
    import hbu_pkg::*;

    t_sample r_tap;
    t_sample n_tap;

    always_comb begin
        n_tap = r_tap;
        if (i_clear) begin
            n_tap = '0;
        end else if (i_advance) begin
            n_tap = i_tap_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else begin
            r_tap <= n_tap;
        end
    end

    assign o_tap = r_tap;

endmodule

@@ src/hbu_mac.sv @@
module hbu_mac (
    input  logic             i_clk,
    input  logic             i_load,
    input  hbu_pkg::t_sample i_taps [hbu_pkg::HIST_DEPTH+1],
    output hbu_pkg::t_sample o_value
);
    import hbu_pkg::*;

    logic signed [SUM_W-1:0] w_sum_inner;
    logic signed [SUM_W-1:0] w_sum_mid;
    logic signed [SUM_W-1:0] w_sum_outer;
    logic signed [ACC_W-1:0] r_prod_inner;
    logic signed [ACC_W-1:0] r_prod_mid;
    logic signed [ACC_W-1:0] r_prod_outer;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [Q_W-1:0]   w_floor;
    logic signed [Q_W-1:0]   w_quot;

    // Fold the symmetric pairs first: taps 2/3, 1/4, 0/new sample.
    assign w_sum_inner = SUM_W'(i_taps[2]) + SUM_W'(i_taps[3]);
    assign w_sum_mid   = SUM_W'(i_taps[1]) + SUM_W'(i_taps[4]);
    assign w_sum_outer = SUM_W'(i_taps[0]) + SUM_W'(i_taps[5]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_inner <= ACC_W'(w_sum_inner) * COEF_INNER;
            r_prod_mid   <= ACC_W'(w_sum_mid) * COEF_MID;
            r_prod_outer <= ACC_W'(w_sum_outer) * COEF_OUTER;
        end
    end

    // Round, truncate toward zero, saturate.
    assign w_acc   = r_prod_inner - r_prod_mid + r_prod_outer + ROUND_HALF;
    assign w_floor = w_acc[ACC_W-1:FRAC_W];
    assign w_quot  = (w_acc[ACC_W-1] && (w_acc[FRAC_W-1:0] != '0))
                     ? w_floor + Q_W'(1) : w_floor;

    always_comb begin
        if (w_quot > SAT_MAX) begin
            o_value = SAMPLE_W'(SAT_MAX);
        end else if (w_quot < SAT_MIN) begin
            o_value = SAMPLE_W'(SAT_MIN);
        end else begin
            o_value = w_quot[SAMPLE_W-1:0];
        end
    end

endmodule

@@ src/halfband_upsampler_2x_core.sv @@
// Half-band 2x interpolator for one 16-bit audio channel. In 2x mode every
// input transaction yields two output transactions: the sample from three
// items earlier (tlast low), then the six-tap half-band value (tlast high).
// In 1x mode each sample passes through as one transaction with tlast high.
// With mute requested and tone mode clear, outputs are zero and the history
// holds. Writing the upsample_mode register clears the history. The design
// takes one input per cycle up to the output rate, while the output is ready:
// two output transactions per item in 2x mode and one in 1x mode, as the single
// output port delivers one result per cycle. An input passes one product stage
// and one output register before its first result. Write configuration
// only while no transaction is in flight.
module halfband_upsampler_2x_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [hbu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [15:0]                     i_s_axis_tdata,  // [15:0] sample_in
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [15:0]                     o_m_axis_tdata,  // [15:0] sample_out
    output logic                            o_m_axis_tlast   // last_of_item
);
    import hbu_pkg::*;

    // Configuration registers
    logic r_upsample_mode;
    logic r_tone_mode;
    logic r_mute_request;
    logic w_hist_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upsample_mode <= 1'b0;
            r_tone_mode     <= 1'b0;
            r_mute_request  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_UPSAMPLE_MODE: r_upsample_mode <= i_cfg_data;
                REG_TONE_MODE:     r_tone_mode     <= i_cfg_data;
                REG_MUTE_REQUEST:  r_mute_request  <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    assign w_hist_clear = i_cfg_wr_en && (i_cfg_index == REG_UPSAMPLE_MODE);

    logic w_mute;
    assign w_mute = !r_tone_mode && r_mute_request;

    // Pipeline handshake
    logic r_s1_valid;
    logic r_s1_two;
    logic r_s1_zero;
    t_sample r_s1_orig;
    logic r_out_valid;
    logic r_out_first;   // first of a pair is on the bus
    t_sample r_out_orig;
    t_sample r_out_interp;

    logic w_s2_free;
    logic w_s1_adv;
    logic w_in_accept;
    logic w_hist_advance;

    assign w_s2_free   = !r_out_valid || (i_m_axis_tready && !r_out_first);
    assign w_s1_adv    = r_s1_valid && w_s2_free;
    assign o_s_axis_tready = !r_s1_valid || w_s2_free;
    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_hist_advance = w_in_accept && r_upsample_mode && !w_mute;

    // History: a chain of tap cells, oldest at index 0, new sample at the end.
    t_sample w_chain [HIST_DEPTH+1];
    assign w_chain[HIST_DEPTH] = i_s_axis_tdata;

    for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_tap
        hbu_tap_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (w_hist_clear),
            .i_advance (w_hist_advance),
            .i_tap_in  (w_chain[g+1]),
            .o_tap     (w_chain[g])
        );
    end

    t_sample w_interp;

    hbu_mac u_mac (
        .i_clk   (i_clk),
        .i_load  (w_in_accept),
        .i_taps  (w_chain),
        .o_value (w_interp)
    );

    // Stage 1: capture the item's control and the original (delayed in 2x mode).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_two  <= r_upsample_mode;
            r_s1_zero <= w_mute;
            r_s1_orig <= r_upsample_mode ? w_chain[2] : t_sample'(i_s_axis_tdata);
        end
    end

    // Output register: a pair drains over two transactions, a 1x result over one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_first <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
            r_out_first <= r_s1_two;
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_out_first) begin
                r_out_first <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_orig <= r_s1_zero ? '0 : r_s1_orig;
            if (r_s1_zero) begin
                r_out_interp <= '0;
            end else if (r_s1_two) begin
                r_out_interp <= w_interp;
            end else begin
                r_out_interp <= r_s1_orig;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_first ? r_out_orig : r_out_interp;
    assign o_m_axis_tlast  = !r_out_first;

    // A stage-1 item that cannot move must still be there next cycle.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s2_free |=> r_s1_valid)
        else $error("stage-1 item dropped while output busy");

    // After the first of a pair is taken, the second must follow.
    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_first && i_m_axis_tready |=>
            o_m_axis_tvalid && o_m_axis_tlast)
        else $error("second result of a pair missing");

    // A muted item, with no register write in the same cycle, leaves the history untouched.
    a_mute_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept && w_mute && !i_cfg_wr_en |=> $stable(w_chain[0])
            && $stable(w_chain[4]))
        else $error("history changed on muted item");

endmodule

@@ verif/halfband_upsampler_2x_core_tb.sv @@
`timescale 1ns / 100ps

module halfband_upsampler_2x_core_tb;
    import hbu_pkg::*;

    // Unlisted register index; writes to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Filter taps at full scale, plus rounding bias and output scaling.
    localparam longint TAP_INNER  = 38400;
    localparam longint TAP_MID    = -6400;
    localparam longint TAP_OUTER  = 768;
    localparam longint ROUND_BIAS = 32768;
    localparam longint OUT_SCALE  = 65536;
    localparam longint CLIP_HI    = 32767;
    localparam longint CLIP_LO    = -32768;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PRESSURE_PHASE  = 2;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_DIR_ROWS    = 34;

    // Sign pattern (oldest first) that drives the interpolator into clipping.
    localparam logic [5:0] CLIP_SIGNS = 6'b101101;

    typedef enum bit {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        bit                    val;
        t_sample               smp;
        bit                    fixed;  // use fval for every result of this item
        t_sample               fval;
    } t_dir_row;

    typedef struct {
        t_sample sample;
        bit      last;
    } t_out_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic                  i_cfg_data = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata = '0;  // [15:0] sample_in
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [15:0]           o_m_axis_tdata;       // [15:0] sample_out
    logic                  o_m_axis_tlast;       // last_of_item

    halfband_upsampler_2x_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Mirror of the block: tap window (oldest first) and the three settings.
    t_sample   tap_window [0:HIST_DEPTH-1] = '{default: '0};
    bit        cfg_mode = 1'b0;
    bit        cfg_tone = 1'b0;
    bit        cfg_mute = 1'b0;

    t_out_beat pending_outputs [$];
    int        err_count = 0;
    int        cycle_count = 0;
    int        rx_hold = 0;
    bit        rx_calm = 1'b0;
    bit        tx_calm = 1'b0;
    bit        long_hold_req = 1'b0;

    // Directed sequence: passthrough extremes, mute, tone override, clipping
    // in both directions, mute in 2x mode, mode rewrite and a spare index.
    t_dir_row dir_tab [NUM_DIR_ROWS] = '{
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh0000, 1'b1, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b1, 16'sh7FFF},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b1, 16'sh8000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh5555, 1'b1, 16'sh5555},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'shAAAA, 1'b1, 16'shAAAA},
        '{ROW_CFG,  REG_MUTE_REQUEST,  1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh3039, 1'b1, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'shFFFF, 1'b1, 16'sh0000},
        '{ROW_CFG,  REG_TONE_MODE,     1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh03E8, 1'b1, 16'sh03E8},
        '{ROW_CFG,  REG_TONE_MODE,     1'b0, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_MUTE_REQUEST,  1'b0, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_UPSAMPLE_MODE, 1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8000, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_MUTE_REQUEST,  1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh1234, 1'b1, 16'sh0000},
        '{ROW_CFG,  REG_TONE_MODE,     1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh4321, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_MUTE_REQUEST,  1'b0, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_UPSAMPLE_MODE, 1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh7FFF, 1'b0, 16'sh0000},
        '{ROW_CFG,  REG_SPARE,         1'b1, 16'sh0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, REG_SPARE, 1'b0, 16'sh8001, 1'b0, 16'sh0000}
    };

    // Free-running 500 MHz clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("halfband_upsampler_2x_core_tb: done, errors");
            $finish;
        end
    end

    // Idle cycles before the next transaction; calm phases never idle.
    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return int'($urandom_range(1, 13));
    endfunction

    // Apply a register write to the mirrored settings.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx, input bit val);
        case (idx)
            REG_UPSAMPLE_MODE: begin
                cfg_mode   = val;
                tap_window = '{default: '0};  // any mode write flushes history
            end
            REG_TONE_MODE:    cfg_tone = val;
            REG_MUTE_REQUEST: cfg_mute = val;
            default: ;                       // unlisted index: drop
        endcase
    endfunction

    // Compute the results of one input sample and, in unmuted 2x mode, advance the tap window.
    // Returns the number of results (1 in passthrough, 2 in 2x mode).
    function automatic int upsample_predict(input t_sample s, output t_sample first,
                                            output t_sample second);
        bit     muted;
        longint acc;
        longint q;
        int     k;
        muted  = !cfg_tone && cfg_mute;
        first  = '0;
        second = '0;
        if (!cfg_mode) begin
            if (!muted)
                first = s;
            return 1;
        end
        if (!muted) begin
            acc = TAP_INNER * (longint'(tap_window[2]) + longint'(tap_window[3]))
                + TAP_MID   * (longint'(tap_window[1]) + longint'(tap_window[4]))
                + TAP_OUTER * (longint'(tap_window[0]) + longint'(s));
            // Signed division truncates toward zero, as required.
            q = (acc + ROUND_BIAS) / OUT_SCALE;
            if (q > CLIP_HI) q = CLIP_HI;
            if (q < CLIP_LO) q = CLIP_LO;
            first  = tap_window[2];
            second = t_sample'(q);
            for (k = 0; k < HIST_DEPTH - 1; k++)
                tap_window[k] = tap_window[k + 1];
            tap_window[HIST_DEPTH - 1] = s;
        end
        return 2;
    endfunction

    // Compare one output transaction with the oldest pending result.
    function automatic void check_beat();
        t_out_beat want;
        if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected output, expected none, actual sample %0d last %0b",
                     $time, $signed(o_m_axis_tdata), o_m_axis_tlast);
            err_count++;
            return;
        end
        want = pending_outputs.pop_front();
        if (o_m_axis_tdata !== want.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want.sample, $signed(o_m_axis_tdata));
            err_count++;
        end
        if (o_m_axis_tlast !== want.last) begin
            $display("%0t: last_of_item mismatch, expected %0b, actual %0b",
                     $time, want.last, o_m_axis_tlast);
            err_count++;
        end
    endfunction

    // Output side: check every accepted transaction, then draw the next stall.
    // A long hold, when requested, loads the hold count with LONG_HOLD and keeps
    // tready low until it runs out, so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_beat();
                rx_hold = draw_gap(rx_calm);
            end
            if (long_hold_req) begin
                rx_hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold--;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one sample; on acceptance queue its results. Called at a clock
    // edge. Valid stays high into the next item when no gap is drawn.
    task automatic send_sample(input t_sample s, input bit fixed, input t_sample fval);
        int      gap;
        int      n;
        t_sample r0;
        t_sample r1;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n = upsample_predict(s, r0, r1);
        if (fixed) begin
            r0 = fval;
            r1 = fval;
        end
        if (n == 1) begin
            pending_outputs.push_back('{sample: r0, last: 1'b1});
        end else begin
            pending_outputs.push_back('{sample: r0, last: 1'b0});
            pending_outputs.push_back('{sample: r1, last: 1'b1});
        end
    endtask

    // Stop offering, wait for every pending result, then let the pipe settle.
    task automatic drain_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; ends at an edge with the write strobe already low.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_reg_write(idx, val);
        @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return t_sample'($urandom);
        if (pick < 8)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        return t_sample'(int'($urandom_range(0, 512)) - 256);
    endfunction

    // Near-full-scale sample following the clipping sign pattern.
    function automatic t_sample clip_sample(input int k, input bit flip);
        if (CLIP_SIGNS[k] ^ flip)
            return t_sample'(int'($urandom_range(32000, 32767)));
        return t_sample'(-int'($urandom_range(32000, 32768)));
    endfunction

    initial begin
        int r;
        int p;
        int k;
        int sent;
        bit flip;
        bit mode_v;
        bit tone_v;
        bit mute_v;

        // Hold reset, then release it once.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: walk the table.
        for (r = 0; r < NUM_DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                drain_block();
                write_reg(dir_tab[r].idx, dir_tab[r].val);
            end else begin
                send_sample(dir_tab[r].smp, dir_tab[r].fixed, dir_tab[r].fval);
            end
        end

        // Random phases. The first four pin down the extreme settings; the
        // pressure phase streams without gaps into a long output stall.
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_block();
            case (p)
                0: {mode_v, tone_v, mute_v} = 3'b100;
                1: {mode_v, tone_v, mute_v} = 3'b011;
                2: {mode_v, tone_v, mute_v} = 3'b100;
                3: {mode_v, tone_v, mute_v} = 3'b111;
                default: begin
                    mode_v = ($urandom_range(0, 3) != 0);
                    tone_v = 1'($urandom_range(0, 1));
                    mute_v = ($urandom_range(0, 4) == 0);
                end
            endcase
            // Skip the mode write now and then so history carries across phases.
            if (p < 4 || mode_v != cfg_mode || $urandom_range(0, 1))
                write_reg(REG_UPSAMPLE_MODE, mode_v);
            write_reg(REG_TONE_MODE, tone_v);
            write_reg(REG_MUTE_REQUEST, mute_v);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, 1'($urandom_range(0, 1)));

            tx_calm = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
            rx_calm = (p != PRESSURE_PHASE) && ($urandom_range(0, 3) == 0);
            if (p == PRESSURE_PHASE)
                long_hold_req = 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 19) == 0) begin
                    flip = 1'($urandom_range(0, 1));
                    for (k = 0; k < 6; k++) begin
                        send_sample(clip_sample(k, flip), 1'b0, '0);
                        sent++;
                    end
                end else begin
                    send_sample(rand_sample(), 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_block();
        if (err_count == 0)
            $display("halfband_upsampler_2x_core_tb: done, clean");
        else
            $display("halfband_upsampler_2x_core_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/hbu_pkg.sv
src/hbu_tap_cell.sv
src/hbu_mac.sv
src/halfband_upsampler_2x_core.sv
verif/halfband_upsampler_2x_core_tb.sv
